// ===== hw/rtl/sorted_integer_list_macros.svh =====
// Assertion macros shared by the sorted integer list RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SORTED_INTEGER_LIST_MACROS_SVH
`define SORTED_INTEGER_LIST_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define SIL_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

// When the trigger holds, the consequence must hold at the next clock edge.
`define SIL_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("next-cycle property violated");

`endif

// ===== hw/rtl/sil_pkg.sv =====
// Shared types, opcodes, status codes and sizes of the sorted integer list.
// No dependencies; used by every module of the block.
`default_nettype none

package sil_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef logic signed [31:0] entry_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [4:0]         count_out_type;
   typedef logic [2:0]         opcode_type;
   typedef logic [1:0]         status_type;

   localparam count_type FULL_COUNT = count_type'(CAPACITY);

   localparam opcode_type OP_INSERT       = 3'd0;
   localparam opcode_type OP_REMOVE_MIN   = 3'd1;
   localparam opcode_type OP_REMOVE_MAX   = 3'd2;
   localparam opcode_type OP_REMOVE_VALUE = 3'd3;
   localparam opcode_type OP_EXISTS       = 3'd4;
   localparam opcode_type OP_CLEAR        = 3'd5;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_EMPTY     = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic publish;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sil_ctrl.sv =====
// Sequencing controller of the sorted integer list: load, execute, publish.
// Depends on sil_pkg for the datapath command struct.
`default_nettype none

module sil_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   output sil_pkg::dp_cmd_type cmd
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_EXEC    = 2'd1;
   localparam logic [1:0] S_PUBLISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC:    state_in = S_PUBLISH;
         S_PUBLISH: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign cmd.load    = start && (state_ff == S_IDLE);
   assign cmd.exec    = (state_ff == S_EXEC);
   assign cmd.publish = (state_ff == S_PUBLISH);

endmodule

`default_nettype wire

// ===== hw/rtl/sil_datapath.sv =====
// Datapath of the sorted integer list: request latch, sorted entry array with
// parallel compare and shift, count, and registered result.
// Depends on sil_pkg and on sorted_integer_list_macros.svh for assertions.
`default_nettype none
`include "sorted_integer_list_macros.svh"

module sil_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  sil_pkg::dp_cmd_type          cmd,
   input  wire  [2:0]                   req_opcode,
   input  wire  signed [31:0]           req_value,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_found,
   output logic signed [31:0]           rsp_min_value,
   output logic signed [31:0]           rsp_max_value,
   output logic [4:0]                   rsp_entry_count,
   output logic                         rsp_is_empty
);

   localparam int CAP = sil_pkg::CAPACITY;

   sil_pkg::opcode_type op_ff;
   sil_pkg::entry_type  val_ff;

   sil_pkg::entry_type  entry_ff [CAP];
   sil_pkg::entry_type  entry_in [CAP];
   sil_pkg::count_type  count_ff;
   sil_pkg::count_type  count_in;
   sil_pkg::status_type status_ff;
   sil_pkg::status_type status_in;
   logic                found_ff;
   logic                found_in;

   sil_pkg::entry_type  ins_entry [CAP];
   sil_pkg::entry_type  del_entry [CAP];
   sil_pkg::entry_type  shl_entry [CAP];
   logic [CAP-1:0]      gt_vec;
   logic [CAP-1:0]      ge_vec;
   logic [CAP-1:0]      eq_vec;
   logic                hit;
   logic                empty;
   sil_pkg::count_type  count_dec;
   sil_pkg::count_type  count_inc;

   logic                rsp_valid_ff;
   sil_pkg::status_type rsp_status_ff;
   logic                rsp_found_ff;
   sil_pkg::entry_type  rsp_min_ff;
   sil_pkg::entry_type  rsp_max_ff;
   sil_pkg::count_type  rsp_count_ff;
   sil_pkg::count_type  last_pos;
   sil_pkg::idx_type    last_idx;

   // Each entry compares itself with the request value. Because the array is
   // sorted, gt_vec and ge_vec are thermometer codes over the valid entries.
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         gt_vec[i] = (count_ff > sil_pkg::count_type'(i)) && (val_ff > entry_ff[i]);
         ge_vec[i] = (count_ff > sil_pkg::count_type'(i)) && (entry_ff[i] >= val_ff);
         eq_vec[i] = (count_ff > sil_pkg::count_type'(i)) && (entry_ff[i] == val_ff);
      end
   end

   assign hit       = |eq_vec;
   assign empty     = (count_ff == '0);
   assign count_dec = count_ff - sil_pkg::count_type'(1);
   assign count_inc = count_ff + sil_pkg::count_type'(1);

   // Insert before the first entry that is not smaller; remove shifts the
   // tail down by one from the first entry that is not smaller.
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         if (gt_vec[i]) begin
            ins_entry[i] = entry_ff[i];
         end else if (i == 0) begin
            ins_entry[i] = val_ff;
         end else if (gt_vec[(i == 0) ? 0 : i - 1]) begin
            ins_entry[i] = val_ff;
         end else begin
            ins_entry[i] = entry_ff[(i == 0) ? 0 : i - 1];
         end
         if (i < CAP - 1) begin
            shl_entry[i] = entry_ff[(i < CAP - 1) ? i + 1 : i];
            del_entry[i] = ge_vec[i] ? entry_ff[(i < CAP - 1) ? i + 1 : i] : entry_ff[i];
         end else begin
            shl_entry[i] = entry_ff[i];
            del_entry[i] = entry_ff[i];
         end
      end
   end

   always_comb begin
      entry_in  = entry_ff;
      count_in  = count_ff;
      status_in = sil_pkg::ST_OK;
      found_in  = 1'b0;
      case (op_ff)
         sil_pkg::OP_INSERT: begin
            if (count_ff >= sil_pkg::FULL_COUNT) begin
               status_in = sil_pkg::ST_FULL;
            end else begin
               entry_in = ins_entry;
               count_in = count_inc;
            end
         end
         sil_pkg::OP_REMOVE_MIN: begin
            if (empty) begin
               status_in = sil_pkg::ST_EMPTY;
            end else begin
               entry_in = shl_entry;
               count_in = count_dec;
            end
         end
         sil_pkg::OP_REMOVE_MAX: begin
            if (empty) begin
               status_in = sil_pkg::ST_EMPTY;
            end else begin
               count_in = count_dec;
            end
         end
         sil_pkg::OP_REMOVE_VALUE: begin
            if (empty) begin
               status_in = sil_pkg::ST_EMPTY;
            end else if (hit) begin
               found_in = 1'b1;
               entry_in = del_entry;
               count_in = count_dec;
            end else begin
               status_in = sil_pkg::ST_NOT_FOUND;
            end
         end
         sil_pkg::OP_EXISTS: found_in = hit;
         sil_pkg::OP_CLEAR:  count_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         val_ff <= req_value;
      end
      if (cmd.exec) begin
         entry_ff  <= entry_in;
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   // The maximum is read in the cycle after the update, from the new last entry.
   assign last_pos = count_ff - sil_pkg::count_type'(1);
   assign last_idx = last_pos[sil_pkg::IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= count_ff;
         rsp_min_ff    <= (count_ff == '0) ? '0 : entry_ff[0];
         rsp_max_ff    <= (count_ff == '0) ? '0 : entry_ff[last_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.publish;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_max_value   = rsp_max_ff;
   assign rsp_entry_count = sil_pkg::count_out_type'(rsp_count_ff);
   assign rsp_is_empty    = (rsp_count_ff == '0);

   `SIL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= sil_pkg::FULL_COUNT)
   `SIL_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.exec && (op_ff == sil_pkg::OP_CLEAR), count_ff == '0)
   `SIL_ASSERT_NEXT(a_full_insert_keeps, clock, reset, cmd.exec && (op_ff == sil_pkg::OP_INSERT) && (count_ff == sil_pkg::FULL_COUNT), $stable(count_ff) && (status_ff == sil_pkg::ST_FULL))

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_integer_list.sv =====
// Sorted integer list top level: a bounded double-ended priority queue.
// Each request passes in turn through the controller's load, execute and publish steps over
// the shared entry array, and its result strobe follows the publish step; a new request is
// accepted only once the controller is back in idle after publishing the previous one.
// Synchronous active-high reset empties the store; entry contents are not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module sorted_integer_list (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire  [2:0]          req_opcode,
   input  wire  signed [31:0]  req_value,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic                rsp_found,
   output logic signed [31:0]  rsp_min_value,
   output logic signed [31:0]  rsp_max_value,
   output logic [4:0]          rsp_entry_count,
   output logic                rsp_is_empty
);

   sil_pkg::dp_cmd_type cmd;

   sil_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   sil_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_min_value   (rsp_min_value),
      .rsp_max_value   (rsp_max_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

`default_nettype wire
